// ----- rtl/blk256_pkg.sv -----
// Package: BLAKE-256 core types, constants and helper functions.
`default_nettype none
package blk256_pkg;

  localparam int ROUND_COUNT_DEF = 14;
  localparam int SALT_REG_COUNT  = 4;
  localparam int CFG_INDEX_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_WORD_3 = 3'd3;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [31:0] bit_count_low;
    logic [31:0] bit_count_high;
    logic        first_block;
    logic        final_block;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } digest_item_t;

  localparam logic [0:15][31:0] PI_CONST = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
    32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
    32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
    32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917
  };

  localparam logic [0:7][31:0] IV_WORDS = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [0:9][0:15][3:0] SIGMA = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  localparam logic [3:0] SIGMA_LAST_ROW = 4'd9;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    rotr32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/blake256_hash_core_top.sv -----
// BLAKE-256 core top level: message word intake, round sequencer, chain fold, digest output.
// Words one to fifteen of a block are stored in the message buffer as they are accepted.
// The sixteenth word starts compression: ROUND_COUNT rounds on the shared G quarter-step
// unit, then the chain fold, then for a final block eight digest transactions at up to one
// per cycle while digest_ready is high. Input and salt writes are held off during compression.
// Synchronous active-high reset: chain value to the IV, salt to zero, word position to zero.
`default_nettype none
module blake256_hash_core_top #(
  parameter int ROUND_COUNT = blk256_pkg::ROUND_COUNT_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   msg_valid,
  output logic                                  msg_ready,
  input  wire blk256_pkg::msg_item_t            msg,
  output logic                                  digest_valid,
  input  wire                                   digest_ready,
  output blk256_pkg::digest_item_t              digest,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [blk256_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [31:0]                            cfg_data
);
  import blk256_pkg::*;

  localparam int RW = $clog2(ROUND_COUNT);

  typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT} state_t;

  state_t                  state;
  logic [3:0]              word_pos;
  logic [15:0][31:0]       mblk;
  logic [7:0][31:0]        chain;
  logic [3:0][31:0]        salt;
  logic [3:0][3:0][31:0]   v;
  logic                    final_flag;
  logic [1:0]              phase;
  logic [2:0]              g_idx;
  logic [RW-1:0]           round;
  logic [3:0]              sig_row;
  logic [2:0]              out_idx;

  logic                    msg_take;
  logic                    block_done;
  logic [7:0][31:0]        chain_base;
  logic [3:0]              sig_p;
  logic [3:0]              sig_q;
  logic [31:0]             msg_op;
  logic [31:0]             add_x;
  logic [31:0]             add_y;
  logic [31:0]             add_z;
  logic [31:0]             sum;
  logic [31:0]             mix;
  logic [31:0]             rot;
  logic [3:0][3:0][31:0]   vcol;
  logic [3:0][3:0][31:0]   v_next;
  logic [3:0][1:0]         shift_amt;
  logic [7:0][31:0]        chain_fold;

  assign cfg_ready    = ((state == ST_LOAD) || (state == ST_OUT))
                        && !(msg_valid && (word_pos == 4'd15));
  assign msg_ready    = (state == ST_LOAD) || ((state == ST_OUT) && (word_pos != 4'd15));
  assign msg_take     = msg_valid && msg_ready;
  assign block_done   = msg_take && (word_pos == 4'd15);
  assign digest_valid = (state == ST_OUT);

  always_comb begin
    digest.digest_word = chain[out_idx];
    digest.digest_last = (out_idx == 3'd7);
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      chain_base[k] = msg.first_block ? IV_WORDS[k] : chain[k];
    end
  end

  always_comb begin
    sig_p  = SIGMA[sig_row][{g_idx, phase[1]}];
    sig_q  = SIGMA[sig_row][{g_idx, ~phase[1]}];
    msg_op = mblk[sig_p] ^ PI_CONST[sig_q];
    add_x  = phase[0] ? v[2][0] : v[0][0];
    add_y  = phase[0] ? v[3][0] : v[1][0];
    add_z  = phase[0] ? 32'd0 : msg_op;
    sum    = add_x + add_y + add_z;
    mix    = (phase[0] ? v[1][0] : v[3][0]) ^ sum;
    case (phase)
      2'd0:    rot = rotr32(mix, 16);
      2'd1:    rot = rotr32(mix, 12);
      2'd2:    rot = rotr32(mix, 8);
      default: rot = rotr32(mix, 7);
    endcase
    vcol = v;
    if (!phase[0]) begin
      vcol[0][0] = sum;
      vcol[3][0] = rot;
    end else begin
      vcol[2][0] = sum;
      vcol[1][0] = rot;
    end
    for (int r = 0; r < 4; r++) begin
      if (g_idx == 3'd3) begin
        shift_amt[r] = 2'(1 + r);
      end else if (g_idx == 3'd7) begin
        shift_amt[r] = 2'(1 - r);
      end else begin
        shift_amt[r] = 2'd1;
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        if (phase == 2'd3) begin
          v_next[r][j] = vcol[r][2'(j) + shift_amt[r]];
        end else begin
          v_next[r][j] = vcol[r][j];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      chain_fold[k]     = chain[k] ^ salt[k] ^ v[0][k] ^ v[2][k];
      chain_fold[k + 4] = chain[k + 4] ^ salt[k] ^ v[1][k] ^ v[3][k];
    end
  end

  always_ff @(posedge clk) begin
    if (msg_take) begin
      mblk[word_pos] <= msg.msg_word;
    end
    if (rst) begin
      state      <= ST_LOAD;
      word_pos   <= 4'd0;
      for (int k = 0; k < 8; k++) begin
        chain[k] <= IV_WORDS[k];
      end
      salt       <= '0;
      final_flag <= 1'b0;
      phase      <= 2'd0;
      g_idx      <= 3'd0;
      round      <= '0;
      sig_row    <= 4'd0;
      out_idx    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(SALT_REG_COUNT))) begin
        salt[cfg_index[1:0]] <= cfg_data;
      end
      if (msg_take) begin
        word_pos <= word_pos + 4'd1;
      end
      case (state)
        ST_LOAD: begin
          if (block_done) begin
            chain      <= chain_base;
            final_flag <= msg.final_block;
            v[0]       <= chain_base[3:0];
            v[1]       <= chain_base[7:4];
            for (int k = 0; k < 4; k++) begin
              v[2][k] <= salt[k] ^ PI_CONST[k];
            end
            v[3][0]    <= msg.bit_count_low ^ PI_CONST[4];
            v[3][1]    <= msg.bit_count_low ^ PI_CONST[5];
            v[3][2]    <= msg.bit_count_high ^ PI_CONST[6];
            v[3][3]    <= msg.bit_count_high ^ PI_CONST[7];
            phase      <= 2'd0;
            g_idx      <= 3'd0;
            round      <= '0;
            sig_row    <= 4'd0;
            state      <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          v     <= v_next;
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            g_idx <= g_idx + 3'd1;
            if (g_idx == 3'd7) begin
              round   <= round + RW'(1);
              sig_row <= (sig_row == SIGMA_LAST_ROW) ? 4'd0 : sig_row + 4'd1;
              if (round == RW'(ROUND_COUNT - 1)) begin
                state <= ST_FOLD;
              end
            end
          end
        end
        ST_FOLD: begin
          chain   <= chain_fold;
          out_idx <= 3'd0;
          state   <= final_flag ? ST_OUT : ST_LOAD;
        end
        ST_OUT: begin
          if (digest_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
